### src/spi_pkg.sv
// Shared types and constants for the segment pair intersection core.
// No dependencies; imported by spi_divider, segment_pair_intersection_core and the testbench.
`timescale 1ns / 1ps

package spi_pkg;

  // Width of every coordinate port, fixed by the interface.
  localparam int FIELD_W = 32;

  // Control bits that travel with a transaction through the divider.
  typedef struct packed {
    logic valid;
    logic hit;
  } spi_ctl_t;

  // Per-axis sideband carried alongside the quotient.
  typedef struct packed {
    logic               neg;    // direction component is negative
    logic [FIELD_W-1:0] start;  // start coordinate, sign-extended
  } spi_side_t;

endpackage

### src/spi_divider.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor.
// Depends on spi_pkg for the control and sideband types.
`timescale 1ns / 1ps

module spi_divider #(
  parameter int COORD_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  spi_pkg::spi_ctl_t              ctl_in,
  input  logic [2*COORD_BITS+1:0]        den_in,
  input  logic [1:0][3*COORD_BITS+1:0]   num_in,
  input  spi_pkg::spi_side_t [1:0]       side_in,
  output spi_pkg::spi_ctl_t              ctl_out,
  output logic [1:0][COORD_BITS:0]       quo_out,
  output spi_pkg::spi_side_t [1:0]       side_out
);
  import spi_pkg::*;

  localparam int Q_W = COORD_BITS + 1;
  localparam int D_W = 2 * COORD_BITS + 2;
  localparam int N_W = 3 * COORD_BITS + 2;

  spi_ctl_t                  ctl  [Q_W];
  logic [D_W-1:0]            den  [Q_W];
  logic [1:0][D_W-1:0]       rem  [Q_W];
  logic [1:0][Q_W-1:0]       nlow [Q_W];
  logic [1:0][Q_W-1:0]       quo  [Q_W];
  spi_side_t [1:0]           side [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    spi_ctl_t            c_src;
    logic [D_W-1:0]      d_src;
    logic [1:0][D_W-1:0] r_src;
    logic [1:0][Q_W-1:0] n_src;
    logic [1:0][Q_W-1:0] q_src;
    spi_side_t [1:0]     s_src;
    logic [1:0][D_W:0]   trial;
    logic [1:0]          ge;

    if (k == 0) begin : g_first
      // Upper numerator bits already sit below the divisor.
      assign c_src = ctl_in;
      assign d_src = den_in;
      assign r_src[0] = D_W'(num_in[0][N_W-1:Q_W]);
      assign r_src[1] = D_W'(num_in[1][N_W-1:Q_W]);
      assign n_src[0] = num_in[0][Q_W-1:0];
      assign n_src[1] = num_in[1][Q_W-1:0];
      assign q_src = '0;
      assign s_src = side_in;
    end else begin : g_rest
      assign c_src = ctl[k-1];
      assign d_src = den[k-1];
      assign r_src = rem[k-1];
      assign n_src = nlow[k-1];
      assign q_src = quo[k-1];
      assign s_src = side[k-1];
    end

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        trial[l] = {r_src[l], n_src[l][Q_W-1]};
        ge[l]    = trial[l] >= {1'b0, d_src};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[k] <= '0;
      end else begin
        ctl[k] <= c_src;
      end
    end

    always_ff @(posedge clk) begin
      den[k]  <= d_src;
      side[k] <= s_src;
      for (int l = 0; l < 2; l++) begin
        rem[k][l]  <= ge[l] ? D_W'(trial[l] - {1'b0, d_src}) : trial[l][D_W-1:0];
        nlow[k][l] <= {n_src[l][Q_W-2:0], 1'b0};
        quo[k][l]  <= {q_src[l][Q_W-2:0], ge[l]};
      end
    end
  end

  assign ctl_out  = ctl[Q_W-1];
  assign quo_out  = quo[Q_W-1];
  assign side_out = side[Q_W-1];

endmodule

### src/segment_pair_intersection_core.sv
// Top level of the segment pair intersection core: cross products, hit test and point.
// Depends on spi_pkg and spi_divider.
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// --------  ---------  ------------------  ----------------------------------------------
// request   in         start high, busy lo a/b start/end x/y, 32-bit signed each
// result    out        done strobe         hit, point_x, point_y
//
// One transaction enters per clock; busy is never raised.
// The divider resolves one quotient bit per stage over COORD_BITS + 1 stages; it
// follows six arithmetic stages and feeds the registered outputs.
// Synchronous reset clears every valid bit; data registers are not reset.
// Results are presented for exactly one cycle with done; the receiver cannot stall.

module segment_pair_intersection_core #(
  parameter int COORD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [spi_pkg::FIELD_W-1:0]  a_start_x,
  input  logic signed [spi_pkg::FIELD_W-1:0]  a_start_y,
  input  logic signed [spi_pkg::FIELD_W-1:0]  a_end_x,
  input  logic signed [spi_pkg::FIELD_W-1:0]  a_end_y,
  input  logic signed [spi_pkg::FIELD_W-1:0]  b_start_x,
  input  logic signed [spi_pkg::FIELD_W-1:0]  b_start_y,
  input  logic signed [spi_pkg::FIELD_W-1:0]  b_end_x,
  input  logic signed [spi_pkg::FIELD_W-1:0]  b_end_y,
  output logic                                done,
  output logic                                hit,
  output logic signed [spi_pkg::FIELD_W-1:0]  point_x,
  output logic signed [spi_pkg::FIELD_W-1:0]  point_y
);
  import spi_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int X_W = 2 * C + 3;  // cross products, signed
  localparam int M_W = 2 * C + 2;  // cross magnitudes, unsigned
  localparam int N_W = 3 * C + 2;  // dividend

  // Never stall the request side.
  assign busy = 1'b0;

  // ---------------- Stage 1: coordinates and direction vectors ----------------
  logic signed [C:0] axs, ays, axe, aye, bxs, bys, bxe, bye;

  // Use only the low COORD_BITS of each field, sign-extended by one bit.
  assign axs = $signed({a_start_x[C-1], a_start_x[C-1:0]});
  assign ays = $signed({a_start_y[C-1], a_start_y[C-1:0]});
  assign axe = $signed({a_end_x[C-1], a_end_x[C-1:0]});
  assign aye = $signed({a_end_y[C-1], a_end_y[C-1:0]});
  assign bxs = $signed({b_start_x[C-1], b_start_x[C-1:0]});
  assign bys = $signed({b_start_y[C-1], b_start_y[C-1:0]});
  assign bxe = $signed({b_end_x[C-1], b_end_x[C-1:0]});
  assign bye = $signed({b_end_y[C-1], b_end_y[C-1:0]});

  logic                      s1_valid;
  logic signed [C:0]         s1_dax, s1_day, s1_dbx, s1_dby, s1_dx, s1_dy;
  logic signed [FIELD_W-1:0] s1_ax, s1_ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_dax <= axe - axs;
    s1_day <= aye - ays;
    s1_dbx <= bxe - bxs;
    s1_dby <= bye - bys;
    s1_dx  <= bxs - axs;
    s1_dy  <= bys - ays;
    s1_ax  <= FIELD_W'($signed(a_start_x[C-1:0]));
    s1_ay  <= FIELD_W'($signed(a_start_y[C-1:0]));
  end

  // ---------------- Stage 2: six signed products ----------------
  logic                      s2_valid;
  logic signed [M_W-1:0]     s2_pcr1, s2_pcr2, s2_pt1, s2_pt2, s2_pu1, s2_pu2;
  logic signed [C:0]         s2_dax, s2_day;
  logic signed [FIELD_W-1:0] s2_ax, s2_ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_pcr1 <= s1_dax * s1_dby;
    s2_pcr2 <= s1_day * s1_dbx;
    s2_pt1  <= s1_dx * s1_dby;
    s2_pt2  <= s1_dy * s1_dbx;
    s2_pu1  <= s1_dx * s1_day;
    s2_pu2  <= s1_dy * s1_dax;
    s2_dax  <= s1_dax;
    s2_day  <= s1_day;
    s2_ax   <= s1_ax;
    s2_ay   <= s1_ay;
  end

  // ---------------- Stage 3: cross, t and u numerators ----------------
  logic                      s3_valid;
  logic signed [X_W-1:0]     s3_cr, s3_tn, s3_un;
  logic signed [C:0]         s3_dax, s3_day;
  logic signed [FIELD_W-1:0] s3_ax, s3_ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_cr  <= s2_pcr1 - s2_pcr2;
    s3_tn  <= s2_pt1 - s2_pt2;
    s3_un  <= s2_pu1 - s2_pu2;
    s3_dax <= s2_dax;
    s3_day <= s2_day;
    s3_ax  <= s2_ax;
    s3_ay  <= s2_ay;
  end

  // ---------------- Stage 4: make the cross product positive ----------------
  logic                      s4_valid;
  logic                      s4_nz;
  logic signed [X_W-1:0]     s4_cr, s4_tn, s4_un;
  logic [C:0]                s4_adx, s4_ady;
  logic                      s4_negx, s4_negy;
  logic signed [FIELD_W-1:0] s4_ax, s4_ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    // Flip all three together so the ratios keep their sign.
    s4_nz   <= s3_cr != '0;
    s4_cr   <= s3_cr[X_W-1] ? -s3_cr : s3_cr;
    s4_tn   <= s3_cr[X_W-1] ? -s3_tn : s3_tn;
    s4_un   <= s3_cr[X_W-1] ? -s3_un : s3_un;
    s4_adx  <= s3_dax[C] ? (C+1)'(-s3_dax) : (C+1)'(s3_dax);
    s4_ady  <= s3_day[C] ? (C+1)'(-s3_day) : (C+1)'(s3_day);
    s4_negx <= s3_dax[C];
    s4_negy <= s3_day[C];
    s4_ax   <= s3_ax;
    s4_ay   <= s3_ay;
  end

  // ---------------- Stage 5: hit test and partial products ----------------
  logic [C:0] tn_lo, tn_hi;

  // Split t's numerator so each multiply stays within one narrow multiplier.
  assign tn_lo = s4_tn[C:0];
  assign tn_hi = s4_tn[M_W-1:C+1];

  logic                      s5_valid;
  logic                      s5_hit;
  logic [M_W-1:0]            s5_den;
  logic [M_W-1:0]            s5_ppx_lo, s5_ppx_hi, s5_ppy_lo, s5_ppy_hi;
  logic                      s5_negx, s5_negy;
  logic signed [FIELD_W-1:0] s5_ax, s5_ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    // Both parameters in [0,1], endpoints included; a zero cross is a miss.
    s5_hit    <= s4_nz && !s4_tn[X_W-1] && !s4_un[X_W-1] &&
                 (s4_tn <= s4_cr) && (s4_un <= s4_cr);
    s5_den    <= s4_cr[M_W-1:0];
    s5_ppx_lo <= tn_lo * s4_adx;
    s5_ppx_hi <= tn_hi * s4_adx;
    s5_ppy_lo <= tn_lo * s4_ady;
    s5_ppy_hi <= tn_hi * s4_ady;
    s5_negx   <= s4_negx;
    s5_negy   <= s4_negy;
    s5_ax     <= s4_ax;
    s5_ay     <= s4_ay;
  end

  // ---------------- Stage 6: assemble the dividends ----------------
  spi_ctl_t                s6_ctl;
  logic [M_W-1:0]          s6_den;
  logic [1:0][N_W-1:0]     s6_num;
  spi_side_t [1:0]         s6_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_ctl <= '0;
    end else begin
      s6_ctl.valid <= s5_valid;
      s6_ctl.hit   <= s5_hit;
    end
  end

  always_ff @(posedge clk) begin
    s6_den           <= s5_den;
    s6_num[0]        <= N_W'({s5_ppx_hi, {(C+1){1'b0}}}) + N_W'(s5_ppx_lo);
    s6_num[1]        <= N_W'({s5_ppy_hi, {(C+1){1'b0}}}) + N_W'(s5_ppy_lo);
    s6_side[0].neg   <= s5_negx;
    s6_side[0].start <= s5_ax;
    s6_side[1].neg   <= s5_negy;
    s6_side[1].start <= s5_ay;
  end

  // ---------------- Divider: trunc(tn * |delta| / cross) per axis ----------------
  spi_ctl_t            div_ctl;
  logic [1:0][C:0]     div_quo;
  spi_side_t [1:0]     div_side;

  spi_divider #(
    .COORD_BITS (COORD_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (s6_ctl),
    .den_in   (s6_den),
    .num_in   (s6_num),
    .side_in  (s6_side),
    .ctl_out  (div_ctl),
    .quo_out  (div_quo),
    .side_out (div_side)
  );

  // ---------------- Output stage: step along A from its start ----------------
  logic signed [FIELD_W:0] qx, qy, sx, sy, px_sum, py_sum;

  assign qx = $signed((FIELD_W+1)'(div_quo[0]));
  assign qy = $signed((FIELD_W+1)'(div_quo[1]));
  assign sx = $signed({div_side[0].start[FIELD_W-1], div_side[0].start});
  assign sy = $signed({div_side[1].start[FIELD_W-1], div_side[1].start});

  // The point lies on A, so the low bits already hold the sign-extended result.
  assign px_sum = div_side[0].neg ? sx - qx : sx + qx;
  assign py_sum = div_side[1].neg ? sy - qy : sy + qy;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    hit     <= div_ctl.hit;
    point_x <= div_ctl.hit ? px_sum[FIELD_W-1:0] : '0;
    point_y <= div_ctl.hit ? py_sum[FIELD_W-1:0] : '0;
  end

endmodule

### dv/segment_pair_intersection_core_tb.sv
// Testbench for segment_pair_intersection_core: directed and random segment pairs are
// checked against a predictor built on exact wide integer arithmetic.
// Depends on spi_pkg and the core RTL only.
`timescale 1ns / 1ps

module segment_pair_intersection_core_tb;
  import spi_pkg::*;

  // Core latency at 32-bit coordinates; the final wait adds a margin to it.
  localparam int LATENCY     = 40;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic signed [FIELD_W-1:0] ONE     = 32'sh0001_0000;  // 1.0 in Q16.16
  localparam logic signed [FIELD_W-1:0] MOST_N  = 32'sh8000_0000;
  localparam logic signed [FIELD_W-1:0] MOST_P  = 32'sh7fff_ffff;

  // One request transaction: two segments, start and end point each.
  typedef struct {
    logic signed [FIELD_W-1:0] a_start_x, a_start_y, a_end_x, a_end_y;
    logic signed [FIELD_W-1:0] b_start_x, b_start_y, b_end_x, b_end_y;
  } segment_pair_t;

  // One result transaction.
  typedef struct {
    logic                      hit;
    logic signed [FIELD_W-1:0] point_x;
    logic signed [FIELD_W-1:0] point_y;
  } crossing_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [FIELD_W-1:0] a_start_x = '0, a_start_y = '0, a_end_x = '0, a_end_y = '0;
  logic signed [FIELD_W-1:0] b_start_x = '0, b_start_y = '0, b_end_x = '0, b_end_y = '0;
  logic done;
  logic hit;
  logic signed [FIELD_W-1:0] point_x, point_y;

  crossing_t pending_crossings[$];  // expected results, oldest first
  int        mismatch_count = 0;
  int        idle_pct = 15;          // chance in a hundred that a sender cycle is idle
  int        cycle_count = 0;

  segment_pair_intersection_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .a_start_x(a_start_x), .a_start_y(a_start_y), .a_end_x(a_end_x), .a_end_y(a_end_y),
    .b_start_x(b_start_x), .b_start_y(b_start_y), .b_end_x(b_end_x), .b_end_y(b_end_y),
    .done(done), .hit(hit), .point_x(point_x), .point_y(point_y)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Predict the crossing of two segments. All products are formed exactly in 128 bits:
  // directions need 33 bits, cross products 67, and tn times a direction about 100.
  function automatic crossing_t predict_crossing(input segment_pair_t p);
    logic signed [127:0] ax, ay, dax, day, dbx, dby, dx, dy;
    logic signed [127:0] cross_ab, tn, un, qx, qy;
    crossing_t r;
    ax  = p.a_start_x;
    ay  = p.a_start_y;
    dax = 128'(p.a_end_x) - ax;
    day = 128'(p.a_end_y) - ay;
    dbx = 128'(p.b_end_x) - 128'(p.b_start_x);
    dby = 128'(p.b_end_y) - 128'(p.b_start_y);
    dx  = 128'(p.b_start_x) - ax;
    dy  = 128'(p.b_start_y) - ay;
    cross_ab = dax * dby - day * dbx;
    tn       = dx * dby - dy * dbx;
    un       = dx * day - dy * dax;
    r.hit = 1'b0;
    r.point_x = '0;
    r.point_y = '0;
    // A zero cross product means parallel or collinear: always a miss.
    if (cross_ab != 0) begin
      // Normalize to a positive denominator so the range test is plain compares.
      if (cross_ab < 0) begin
        cross_ab = -cross_ab;
        tn = -tn;
        un = -un;
      end
      r.hit = (tn >= 0) && (un >= 0) && (tn <= cross_ab) && (un <= cross_ab);
    end
    if (r.hit) begin
      // Divide magnitudes so the quotient truncates toward zero, then apply the sign.
      qx = (tn * (dax < 0 ? -dax : dax)) / cross_ab;
      qy = (tn * (day < 0 ? -day : day)) / cross_ab;
      qx = (dax < 0) ? ax - qx : ax + qx;
      qy = (day < 0) ? ay - qy : ay + qy;
      r.point_x = qx[FIELD_W-1:0];
      r.point_y = qy[FIELD_W-1:0];
    end
    return r;
  endfunction

  function automatic segment_pair_t pair_of(
    input logic signed [FIELD_W-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2);
    segment_pair_t p;
    p.a_start_x = ax1; p.a_start_y = ay1; p.a_end_x = ax2; p.a_end_y = ay2;
    p.b_start_x = bx1; p.b_start_y = by1; p.b_end_x = bx2; p.b_end_y = by2;
    return p;
  endfunction

  // Uniform value in [-span, span].
  function automatic logic signed [FIELD_W-1:0] rand_in_box(input int unsigned span);
    return $urandom_range(2 * span) - span;
  endfunction

  function automatic logic signed [FIELD_W-1:0] rand_extreme();
    case ($urandom_range(5))
      0: return MOST_N;
      1: return MOST_P;
      2: return '0;
      3: return -1;
      4: return 1;
      default: return $urandom;
    endcase
  endfunction

  // Draw one random pair. Most draws are built to cross, touch, or run parallel so
  // the hit test and the point datapath see real work; the rest is raw noise.
  function automatic segment_pair_t make_random_pair();
    segment_pair_t p;
    logic signed [FIELD_W-1:0] cx, cy, d1x, d1y, d2x, d2y, ox, oy;
    int unsigned span;
    int k1, k2;
    span = 32'd1 << $urandom_range(30, 2);
    case ($urandom_range(9))
      0: p = pair_of($urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
      1: p = pair_of(rand_extreme(), rand_extreme(), rand_extreme(), rand_extreme(),
                     rand_extreme(), rand_extreme(), rand_extreme(), rand_extreme());
      2, 3: p = pair_of(rand_in_box(span), rand_in_box(span), rand_in_box(span),
                        rand_in_box(span), rand_in_box(span), rand_in_box(span),
                        rand_in_box(span), rand_in_box(span));
      4: begin
        // Shared endpoint: B starts on one end of A.
        p = pair_of(rand_in_box(span), rand_in_box(span), rand_in_box(span),
                    rand_in_box(span), '0, '0, rand_in_box(span), rand_in_box(span));
        if ($urandom_range(1)) begin
          p.b_start_x = p.a_end_x;
          p.b_start_y = p.a_end_y;
        end else begin
          p.b_start_x = p.a_start_x;
          p.b_start_y = p.a_start_y;
        end
      end
      5: begin
        // Parallel: shift A by a random offset, or along itself for a collinear pair.
        p = pair_of(rand_in_box(span), rand_in_box(span), rand_in_box(span),
                    rand_in_box(span), '0, '0, '0, '0);
        k1 = $urandom_range(4) - 2;
        if ($urandom_range(1)) begin
          ox = k1 * (p.a_end_x - p.a_start_x);
          oy = k1 * (p.a_end_y - p.a_start_y);
        end else begin
          ox = rand_in_box(span);
          oy = rand_in_box(span);
        end
        p.b_start_x = p.a_start_x + ox; p.b_start_y = p.a_start_y + oy;
        p.b_end_x   = p.a_end_x + ox;   p.b_end_y   = p.a_end_y + oy;
      end
      default: begin
        // Two segments through a common center with random reach on each side.
        cx = rand_in_box(span >> 1); cy = rand_in_box(span >> 1);
        d1x = rand_in_box(span >> 2); d1y = rand_in_box(span >> 2);
        d2x = rand_in_box(span >> 2); d2y = rand_in_box(span >> 2);
        k1 = $urandom_range(3, 0);
        k2 = $urandom_range(3, 0);
        p = pair_of(cx - d1x, cy - d1y, cx + k1 * d1x, cy + k1 * d1y,
                    cx - d2x, cy - d2y, cx + k2 * d2x, cy + k2 * d2y);
      end
    endcase
    return p;
  endfunction

  // Drive one request and hold it until the core takes it; record the prediction at
  // the accepting edge, then drop start for a random number of idle cycles.
  task automatic send_pair(input segment_pair_t p);
    start     <= 1'b1;
    a_start_x <= p.a_start_x; a_start_y <= p.a_start_y;
    a_end_x   <= p.a_end_x;   a_end_y   <= p.a_end_y;
    b_start_x <= p.b_start_x; b_start_y <= p.b_start_y;
    b_end_x   <= p.b_end_x;   b_end_y   <= p.b_end_y;
    do @(posedge clk); while (busy !== 1'b0);
    pending_crossings = {pending_crossings, predict_crossing(p)};
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drop start and hold off until every outstanding transaction has returned.
  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_crossings.size() != 0) @(posedge clk);
  endtask

  // Geometric corner cases: crossings, touches at either end, near misses on each
  // parameter, parallel and collinear pairs, degenerate segments, and full-range values.
  task automatic test_directed_cases();
    segment_pair_t cases[$];
    idle_pct = 15;
    cases = {cases, pair_of(0, 0, 2*ONE, 2*ONE, 0, 2*ONE, 2*ONE, 0)};        // plain X, negative cross
    cases = {cases, pair_of(0, 0, 2*ONE, 2*ONE, 2*ONE, 0, 0, 2*ONE)};        // mirrored X, positive cross
    cases = {cases, pair_of(0, 0, 4*ONE, 0, 0, ONE, 4*ONE, ONE)};            // parallel
    cases = {cases, pair_of(0, 0, 4*ONE, 0, 2*ONE, 0, 6*ONE, 0)};            // collinear overlap
    cases = {cases, pair_of(0, 0, 2*ONE, 2*ONE, 0, 0, 2*ONE, -2*ONE)};       // touch at starts
    cases = {cases, pair_of(0, 0, 2*ONE, 2*ONE, 4*ONE, 0, 2*ONE, 2*ONE)};    // touch at ends
    cases = {cases, pair_of(0, 0, 4*ONE, 0, 2*ONE, 3*ONE, 2*ONE, 0)};        // T junction
    cases = {cases, pair_of(0, 0, 4*ONE, 0, 5*ONE, -ONE, 5*ONE, ONE)};       // past A end
    cases = {cases, pair_of(0, 0, 4*ONE, 0, -ONE, -ONE, -ONE, ONE)};         // before A start
    cases = {cases, pair_of(0, 0, 4*ONE, 0, 2*ONE, ONE, 2*ONE, 3*ONE)};      // B short of A
    cases = {cases, pair_of(ONE, ONE, ONE, ONE, 0, 0, 2*ONE, 2*ONE)};        // zero-length A
    cases = {cases, pair_of(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE)};        // both points
    cases = {cases, pair_of(MOST_N, MOST_N, MOST_N, MOST_N, MOST_N, MOST_N, MOST_N, MOST_N)};
    cases = {cases, pair_of(MOST_P, MOST_P, MOST_P, MOST_P, MOST_P, MOST_P, MOST_P, MOST_P)};
    cases = {cases, pair_of(MOST_N, MOST_N, MOST_P, MOST_P, MOST_N, MOST_P, MOST_P, MOST_N)};
    cases = {cases, pair_of(MOST_P, MOST_P, MOST_N, MOST_N, MOST_P, MOST_N, MOST_N, MOST_P)};
    cases = {cases, pair_of(MOST_P, 0, MOST_N, 0, 0, MOST_P, 0, MOST_N)};    // full-span axes
    cases = {cases, pair_of(MOST_N, MOST_P, MOST_P, MOST_N, -1, -1, 1, 1)};
    cases = {cases, pair_of(0, 0, -3, -1, -1, -1, -1, 1)};                   // truncation, neg
    cases = {cases, pair_of(0, 0, 3, 1, 1, -1, 1, 1)};                       // truncation, pos
    cases = {cases, pair_of(0, 0, MOST_P, MOST_P - 1, 0, 1, MOST_P, MOST_P)}; // parallel at full range
    cases = {cases, pair_of(0, 0, 7, 0, 1, -5, 6, 3)};                       // odd raw units
    foreach (cases[i]) send_pair(cases[i]);
  endtask

  // Random pairs at the normal idle rate.
  task automatic test_random_pairs(input int count);
    idle_pct = 15;
    repeat (count) send_pair(make_random_pair());
  endtask

  // A long stretch with start held high, one transaction per clock.
  task automatic test_back_to_back(input int count);
    idle_pct = 0;
    repeat (count) send_pair(make_random_pair());
    idle_pct = 15;
  endtask

  // Let the pipeline empty completely mid-run, then resume from cold.
  task automatic test_pause_for_results(input int count);
    repeat (count) send_pair(make_random_pair());
    wait_for_results();
    repeat (count) send_pair(make_random_pair());
  endtask

  // Check each result transaction against the oldest expectation.
  always @(posedge clk) begin
    crossing_t want;
    if (!rst && done === 1'b1) begin
      if (pending_crossings.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: hit %0b x %h y %h", hit, point_x, point_y);
        mismatch_count++;
      end else begin
        want = pending_crossings.pop_front();
        if (hit !== want.hit || point_x !== want.point_x || point_y !== want.point_y) begin
          if (mismatch_count < 10)
            $display("mismatch: hit %0b/%0b x %h/%h y %h/%h (expected/actual)",
                     want.hit, hit, want.point_x, point_x, want.point_y, point_y);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_pairs(300);
    test_back_to_back(150);
    test_pause_for_results(25);
    test_random_pairs(250);
    wait_for_results();
    // Hold a little past the latency to catch any stray result.
    repeat (LATENCY + 8) @(posedge clk);
    mismatch_count += pending_crossings.size();
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
